// File: hw/rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler: field widths,
// register codes, reset values and default sizes.
// ----------------------------------------------------------------------------
package bis_pkg;

	// field widths
	localparam int COORD_W   = 8;
	localparam int CHAN_W    = 8;
	localparam int CHANNELS  = 3;
	localparam int PIXEL_W   = CHAN_W * CHANNELS;
	localparam int SIZE_W    = 9;
	localparam int STEP_W    = 21;
	localparam int POS_W     = COORD_W + STEP_W;
	localparam int CFG_W     = STEP_W;
	localparam int CFG_IDX_W = 2;
	localparam int NBR       = 4;

	// default sizes
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 12;

	// register reset values
	localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = 9'd256;
	localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = 9'd256;
	localparam logic [STEP_W-1:0] RST_STEP_X        = 21'd4096;
	localparam logic [STEP_W-1:0] RST_STEP_Y        = 21'd4096;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_STEP_X        = 2'd2,
		REG_STEP_Y        = 2'd3
	} cfg_reg_t;

	// item kind
	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	// parity of the four neighbour coordinates, picks the bank of each
	typedef struct packed {
		logic x0_odd;
		logic x1_odd;
		logic y0_odd;
		logic y1_odd;
	} nbr_sel_t;

endpackage

// File: hw/rtl/bis_channels.sv
// ----------------------------------------------------------------------------
// bis_channels
// Valid/ready channels of the scaler: pixel items in, RGB results out.
// ----------------------------------------------------------------------------
interface bis_in_if;
	logic                            valid;
	logic                            ready;
	bis_pkg::kind_t                  kind;
	logic [bis_pkg::COORD_W-1:0]     col;
	logic [bis_pkg::COORD_W-1:0]     row;
	logic [bis_pkg::CHAN_W-1:0]      in_red;
	logic [bis_pkg::CHAN_W-1:0]      in_green;
	logic [bis_pkg::CHAN_W-1:0]      in_blue;

	modport source (output valid, kind, col, row, in_red, in_green, in_blue, input ready);
	modport sink (input valid, kind, col, row, in_red, in_green, in_blue, output ready);
endinterface

interface bis_out_if;
	logic                            valid;
	logic                            ready;
	logic [bis_pkg::CHAN_W-1:0]      out_red;
	logic [bis_pkg::CHAN_W-1:0]      out_green;
	logic [bis_pkg::CHAN_W-1:0]      out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// File: hw/rtl/bis_bank.sv
// ----------------------------------------------------------------------------
// bis_bank
// One parity bank of the frame store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bis_bank #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [bis_pkg::PIXEL_W-1:0]  wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [bis_pkg::PIXEL_W-1:0]  rdata
);

	logic [bis_pkg::PIXEL_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while the consumer stalls
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/bis_locate.sv
// ----------------------------------------------------------------------------
// bis_locate
// Splits a fixed-point source position into clamped neighbour coordinates
// and the fraction that weights them, for one axis.
// ----------------------------------------------------------------------------
module bis_locate #(
	parameter int MAX_SIZE  = bis_pkg::DEF_MAX_WIDTH,
	parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
	input  logic [bis_pkg::POS_W-1:0]   pos,
	input  logic [bis_pkg::SIZE_W-1:0]  size,
	output logic [$clog2(MAX_SIZE)-1:0] lo,
	output logic [$clog2(MAX_SIZE)-1:0] hi,
	output logic [FRAC_BITS-1:0]        frac
);

	localparam int IW  = $clog2(MAX_SIZE);
	localparam int PIW = bis_pkg::POS_W - FRAC_BITS;
	localparam int CW0 = (PIW > IW + 1) ? PIW : IW + 1;
	localparam int CW  = (CW0 > bis_pkg::SIZE_W) ? CW0 : bis_pkg::SIZE_W;

	logic [CW-1:0] size_ext;
	logic [CW-1:0] last;
	logic [CW-1:0] ipart;
	logic [CW-1:0] lo_c;
	logic [CW-1:0] hi_c;

	// last usable index: zero size acts as one, oversize as the store limit
	always_comb begin
		size_ext = CW'(size);
		if (size_ext == '0) begin
			last = '0;
		end else if (size_ext > CW'(MAX_SIZE)) begin
			last = CW'(MAX_SIZE - 1);
		end else begin
			last = size_ext - CW'(1);
		end
	end

	// integer part saturates at the last index, right neighbour clamped
	always_comb begin
		ipart = CW'(pos >> FRAC_BITS);
		lo_c  = (ipart > last) ? last : ipart;
		hi_c  = (lo_c < last) ? lo_c + CW'(1) : last;
	end

	assign lo   = lo_c[IW-1:0];
	assign hi   = hi_c[IW-1:0];
	assign frac = pos[FRAC_BITS-1:0];

endmodule

// File: hw/rtl/bis_blend.sv
// ----------------------------------------------------------------------------
// bis_blend
// Weighting pipeline: picks the four neighbours out of the banks, forms the
// bilinear weights, multiplies per channel and sums into the result register.
// ----------------------------------------------------------------------------
module bis_blend #(
	parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          take,
	output logic                                          ready,
	input  bis_pkg::nbr_sel_t                             sel,
	input  logic [FRAC_BITS-1:0]                          fx,
	input  logic [FRAC_BITS-1:0]                          fy,
	input  logic [bis_pkg::NBR-1:0][bis_pkg::PIXEL_W-1:0] bank_rd,
	bis_out_if.source                                     pix_out
);

	localparam int WW   = FRAC_BITS + 1;
	localparam int WPW  = 2 * FRAC_BITS + 1;
	localparam int PW   = WPW + bis_pkg::CHAN_W;
	localparam int SUMW = PW + 2;
	localparam int ONE  = 1 << FRAC_BITS;
	localparam int NBR  = bis_pkg::NBR;
	localparam int CH   = bis_pkg::CHANNELS;
	localparam int CHW  = bis_pkg::CHAN_W;

	// stage valids and advance chain
	logic v_s2, v_s3, v_s4, out_valid_q;
	logic adv_s2, adv_s3, adv_s4, adv_out;

	assign adv_out = !out_valid_q || pix_out.ready;
	assign adv_s4  = !v_s4 || adv_out;
	assign adv_s3  = !v_s3 || adv_s4;
	assign adv_s2  = !v_s2 || adv_s3;
	assign ready   = adv_s2;

	// stage 2: fractions and bank selects beside the bank read data
	bis_pkg::nbr_sel_t     sel_s2;
	logic [FRAC_BITS-1:0]  fx_s2, fy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			sel_s2 <= sel;
			fx_s2  <= fx;
			fy_s2  <= fy;
		end
	end

	// neighbour routing and weights
	logic [NBR-1:0][bis_pkg::PIXEL_W-1:0] nbr;
	logic [WW-1:0]                        wx0, wx1, wy0, wy1;
	logic [NBR-1:0][WPW-1:0]              wt;

	always_comb begin
		nbr[0] = bank_rd[{sel_s2.y0_odd, sel_s2.x0_odd}];
		nbr[1] = bank_rd[{sel_s2.y0_odd, sel_s2.x1_odd}];
		nbr[2] = bank_rd[{sel_s2.y1_odd, sel_s2.x0_odd}];
		nbr[3] = bank_rd[{sel_s2.y1_odd, sel_s2.x1_odd}];
		wx1    = WW'(fx_s2);
		wy1    = WW'(fy_s2);
		wx0    = WW'(ONE) - wx1;
		wy0    = WW'(ONE) - wy1;
		wt[0]  = WPW'(wx0) * WPW'(wy0);
		wt[1]  = WPW'(wx1) * WPW'(wy0);
		wt[2]  = WPW'(wx0) * WPW'(wy1);
		wt[3]  = WPW'(wx1) * WPW'(wy1);
	end

	// stage 3: weights and neighbour pixels
	logic [NBR-1:0][WPW-1:0]              wt_s3;
	logic [NBR-1:0][bis_pkg::PIXEL_W-1:0] nbr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			wt_s3  <= wt;
			nbr_s3 <= nbr;
		end
	end

	// per channel products
	logic [CH-1:0][NBR-1:0][PW-1:0] prod;

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			for (int k = 0; k < NBR; k++) begin
				prod[c][k] = PW'(nbr_s3[k][c*CHW +: CHW]) * PW'(wt_s3[k]);
			end
		end
	end

	// stage 4: products
	logic [CH-1:0][NBR-1:0][PW-1:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			prod_s4 <= prod;
		end
	end

	// sum of four and truncation
	logic [CH-1:0][SUMW-1:0] sum;
	logic [CH-1:0][CHW-1:0]  chan;

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			sum[c]  = SUMW'(prod_s4[c][0]) + SUMW'(prod_s4[c][1])
				+ SUMW'(prod_s4[c][2]) + SUMW'(prod_s4[c][3]);
			chan[c] = sum[c][2*FRAC_BITS +: CHW];
		end
	end

	// result register
	logic [CH-1:0][CHW-1:0] chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			chan_q <= chan;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = chan_q[0];
	assign pix_out.out_green = chan_q[1];
	assign pix_out.out_blue  = chan_q[2];

endmodule

// File: hw/rtl/bilinear_image_scaler_core.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_core
// RGB image scaler with bilinear interpolation over a banked frame store.
// ----------------------------------------------------------------------------
// Usage:
// pix_in carries load and query transactions. A load writes one RGB source
// pixel at (col,row) of the frame store and gives no result. A query names a
// destination pixel; the block scales it by step_x/step_y (unsigned Q9.12),
// blends the four source neighbours and returns one RGB transaction on
// pix_out. Right and bottom neighbours clamp to the last column and row.
// Throughput: one transaction per cycle while pix_in.ready is high, loads
// and queries mixed freely. The frame store is split into four banks by
// row and column parity, so the four neighbours are read in the same cycle,
// one read port per bank. A query is registered at acceptance, then passes
// locate and read, weights, products and sum, each into a register, to pix_out.
// Stall: a waiting result holds pix_out; earlier empty stages still fill,
// and pix_in.ready drops only once the pipeline is full.
// Reset clears all valid flags and sets the registers to a 256 x 256
// source at unit step. The frame store is not cleared; pixels must be
// loaded before a query reads them. Configure only while idle.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_core #(
	parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bis_pkg::CFG_W-1:0]       cfg_data,
	bis_in_if.sink                          pix_in,
	bis_out_if.source                       pix_out
);

	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int BANK_W     = (MAX_WIDTH + 1) / 2;
	localparam int BANK_H     = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = BANK_W * BANK_H;
	localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int NBR        = bis_pkg::NBR;

	// configuration registers
	logic [bis_pkg::SIZE_W-1:0] src_w_q, src_h_q;
	logic [bis_pkg::STEP_W-1:0] step_x_q, step_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= bis_pkg::RST_SOURCE_WIDTH;
			src_h_q  <= bis_pkg::RST_SOURCE_HEIGHT;
			step_x_q <= bis_pkg::RST_STEP_X;
			step_y_q <= bis_pkg::RST_STEP_Y;
		end else if (cfg_we) begin
			unique case (bis_pkg::cfg_reg_t'(cfg_index))
				bis_pkg::REG_SOURCE_WIDTH: begin
					src_w_q <= cfg_data[bis_pkg::SIZE_W-1:0];
				end
				bis_pkg::REG_SOURCE_HEIGHT: begin
					src_h_q <= cfg_data[bis_pkg::SIZE_W-1:0];
				end
				bis_pkg::REG_STEP_X: begin
					step_x_q <= cfg_data;
				end
				bis_pkg::REG_STEP_Y: begin
					step_y_q <= cfg_data;
				end
			endcase
		end
	end

	// stage 1: accepted transaction with scaled positions
	logic                          v_s1;
	bis_pkg::kind_t                kind_s1;
	logic [bis_pkg::COORD_W-1:0]   col_s1, row_s1;
	logic [bis_pkg::PIXEL_W-1:0]   pixel_s1;
	logic [bis_pkg::POS_W-1:0]     posx_s1, posy_s1;
	logic                          adv_s1;
	logic                          blend_ready;

	assign adv_s1       = !v_s1 || (kind_s1 == bis_pkg::KIND_LOAD) || blend_ready;
	assign pix_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s1  <= pix_in.kind;
			col_s1   <= pix_in.col;
			row_s1   <= pix_in.row;
			pixel_s1 <= {pix_in.in_blue, pix_in.in_green, pix_in.in_red};
			posx_s1  <= bis_pkg::POS_W'(pix_in.col) * bis_pkg::POS_W'(step_x_q);
			posy_s1  <= bis_pkg::POS_W'(pix_in.row) * bis_pkg::POS_W'(step_y_q);
		end
	end

	// neighbour coordinates per axis
	logic [XW-1:0]        x0, x1;
	logic [YW-1:0]        y0, y1;
	logic [FRAC_BITS-1:0] fx, fy;

	bis_locate #(
		.MAX_SIZE  (MAX_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_locate_x (
		.pos  (posx_s1),
		.size (src_w_q),
		.lo   (x0),
		.hi   (x1),
		.frac (fx)
	);

	bis_locate #(
		.MAX_SIZE  (MAX_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_locate_y (
		.pos  (posy_s1),
		.size (src_h_q),
		.lo   (y0),
		.hi   (y1),
		.frac (fy)
	);

	bis_pkg::nbr_sel_t sel;

	always_comb begin
		sel.x0_odd = x0[0];
		sel.x1_odd = x1[0];
		sel.y0_odd = y0[0];
		sel.y1_odd = y1[0];
	end

	// load write: bank by parity, loads outside the store are dropped
	logic           ld_ok, ld_we;
	logic [1:0]     ld_bank;
	logic [BAW-1:0] ld_addr;

	always_comb begin
		ld_ok   = (32'(col_s1) < MAX_WIDTH) && (32'(row_s1) < MAX_HEIGHT);
		ld_we   = v_s1 && (kind_s1 == bis_pkg::KIND_LOAD) && ld_ok;
		ld_bank = {row_s1[0], col_s1[0]};
		ld_addr = BAW'(32'(row_s1 >> 1) * BANK_W + 32'(col_s1 >> 1));
	end

	// frame store banks, each reads whichever neighbour has its parity
	logic [NBR-1:0][bis_pkg::PIXEL_W-1:0] bank_rd;

	for (genvar b = 0; b < NBR; b++) begin : g_bank
		localparam logic XP = 1'(b % 2);
		localparam logic YP = 1'(b / 2);

		logic [XW-1:0]  rc;
		logic [YW-1:0]  rr;
		logic [BAW-1:0] raddr;
		logic           bwe;

		assign rc    = (x0[0] == XP) ? x0 : x1;
		assign rr    = (y0[0] == YP) ? y0 : y1;
		assign raddr = BAW'(32'(rr >> 1) * BANK_W + 32'(rc >> 1));
		assign bwe   = ld_we && (ld_bank == 2'(b));

		bis_bank #(
			.DEPTH (BANK_DEPTH),
			.AW    (BAW)
		) u_bank (
			.clk   (clk),
			.we    (bwe),
			.waddr (ld_addr),
			.wdata (pixel_s1),
			.re    (blend_ready),
			.raddr (raddr),
			.rdata (bank_rd[b])
		);
	end

	// weighting pipeline and result register
	bis_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (v_s1 && (kind_s1 == bis_pkg::KIND_QUERY)),
		.ready   (blend_ready),
		.sel     (sel),
		.fx      (fx),
		.fy      (fy),
		.bank_rd (bank_rd),
		.pix_out (pix_out)
	);

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear image scaler core. Source pixels are
// loaded into the frame store, the scale registers are swept over several
// settings, and destination pixels are queried; each RGB result is compared
// with an in-bench bilinear predictor. Queries only touch loaded pixels.
// ---------------------------------------------------------------------------
module tb;

	localparam int IMG_W          = bis_pkg::DEF_MAX_WIDTH;
	localparam int IMG_H          = bis_pkg::DEF_MAX_HEIGHT;
	localparam int FRAC           = bis_pkg::DEF_FRAC_BITS;
	localparam int SETTLE         = 8;    // pipeline depth plus margin
	localparam int QUERIES_PHASE  = 100;
	localparam int FIXED_PHASES   = 6;
	localparam int RANDOM_PHASES  = 8;

	typedef struct packed {
		logic [bis_pkg::CHAN_W-1:0] red;
		logic [bis_pkg::CHAN_W-1:0] green;
		logic [bis_pkg::CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		bis_pkg::kind_t              kind;
		logic [bis_pkg::COORD_W-1:0] col;
		logic [bis_pkg::COORD_W-1:0] row;
		rgb_t                        pix;
		logic                        typed;
		rgb_t                        want;
	} vector_t;

	typedef struct packed {
		logic [bis_pkg::SIZE_W-1:0] width;
		logic [bis_pkg::SIZE_W-1:0] height;
		logic [bis_pkg::STEP_W-1:0] sx;
		logic [bis_pkg::STEP_W-1:0] sy;
	} scale_cfg_t;

	typedef struct {
		int              lo;
		int              hi;
		longint unsigned frac;
	} span_t;

	typedef enum int {RX_FLOW, RX_RANDOM, RX_SPARSE} rx_mode_t;

	// directed vectors at the reset setting (256 x 256 source, unit step)
	localparam vector_t DIRECTED [15] = '{
		'{bis_pkg::KIND_LOAD,  8'd0,   8'd0,   24'h000000, 1'b0, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd1,   8'd0,   24'hffffff, 1'b0, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd0,   8'd1,   24'h804020, 1'b0, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd1,   8'd1,   24'h010203, 1'b0, 24'h000000},
		'{bis_pkg::KIND_QUERY, 8'd0,   8'd0,   24'hffffff, 1'b1, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd255, 8'd255, 24'hffffff, 1'b0, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd254, 8'd255, 24'h112233, 1'b0, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd255, 8'd254, 24'h445566, 1'b0, 24'h000000},
		'{bis_pkg::KIND_LOAD,  8'd254, 8'd254, 24'haabbcc, 1'b0, 24'h000000},
		'{bis_pkg::KIND_QUERY, 8'd255, 8'd255, 24'h000000, 1'b1, 24'hffffff},
		'{bis_pkg::KIND_QUERY, 8'd254, 8'd254, 24'h5a5a5a, 1'b1, 24'haabbcc},
		'{bis_pkg::KIND_QUERY, 8'd255, 8'd254, 24'h000000, 1'b1, 24'h445566},
		'{bis_pkg::KIND_QUERY, 8'd254, 8'd255, 24'h000000, 1'b1, 24'h112233},
		'{bis_pkg::KIND_LOAD,  8'd0,   8'd0,   24'h7f8001, 1'b0, 24'h000000},
		'{bis_pkg::KIND_QUERY, 8'd0,   8'd0,   24'h000000, 1'b1, 24'h7f8001}
	};

	// fixed settings: out-of-range sizes, zero and maximum steps, one plain setting
	localparam scale_cfg_t FIXED_CFGS [FIXED_PHASES] = '{
		'{9'd256, 9'd1,   21'd4096,    21'd0},
		'{9'd1,   9'd256, 21'd0,       21'd4096},
		'{9'd511, 9'd0,   21'd2048,    21'd1048576},
		'{9'd0,   9'd511, 21'd2097151, 21'd1365},
		'{9'd2,   9'd2,   21'd2097151, 21'd2097151},
		'{9'd16,  9'd12,  21'd3000,    21'd5461}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bis_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bis_pkg::CFG_W-1:0]     cfg_data;

	bis_in_if  pix_in_ch ();
	bis_out_if pix_out_ch ();

	bilinear_image_scaler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch)
	);

	// bench copy of the frame store and the scale registers
	rgb_t       src_image  [IMG_W*IMG_H];
	bit         src_loaded [IMG_W*IMG_H];
	scale_cfg_t cur_cfg;
	rgb_t       pending_pixels [$];
	int         mismatches;
	int         burst_left;

	function automatic int clamp_size(input logic [bis_pkg::SIZE_W-1:0] reg_val,
			input int limit);
		if (reg_val == 0)
			return 1;
		if (reg_val > limit)
			return limit;
		return int'(reg_val);
	endfunction

	// source position of one axis: neighbour pair and fraction
	function automatic span_t locate_axis(input logic [bis_pkg::COORD_W-1:0] idx,
			input logic [bis_pkg::STEP_W-1:0] step, input int size);
		longint unsigned pos;
		span_t s;
		pos = idx * step;
		s.frac = pos & ((64'd1 << FRAC) - 1);
		if ((pos >> FRAC) > longint'(size - 1))
			s.lo = size - 1;
		else
			s.lo = int'(pos >> FRAC);
		s.hi = (s.lo + 1 < size) ? s.lo + 1 : size - 1;
		return s;
	endfunction

	// expected RGB of a query under the current setting
	function automatic rgb_t interp_pixel(input logic [bis_pkg::COORD_W-1:0] col,
			input logic [bis_pkg::COORD_W-1:0] row);
		span_t xs, ys;
		longint unsigned one, sr, sg, sb;
		longint unsigned wt [bis_pkg::NBR];
		rgb_t nb [bis_pkg::NBR];
		rgb_t res;
		xs = locate_axis(col, cur_cfg.sx, clamp_size(cur_cfg.width, IMG_W));
		ys = locate_axis(row, cur_cfg.sy, clamp_size(cur_cfg.height, IMG_H));
		one = 64'd1 << FRAC;
		wt[0] = (one - xs.frac) * (one - ys.frac);
		wt[1] = xs.frac * (one - ys.frac);
		wt[2] = (one - xs.frac) * ys.frac;
		wt[3] = xs.frac * ys.frac;
		nb[0] = src_image[ys.lo*IMG_W + xs.lo];
		nb[1] = src_image[ys.lo*IMG_W + xs.hi];
		nb[2] = src_image[ys.hi*IMG_W + xs.lo];
		nb[3] = src_image[ys.hi*IMG_W + xs.hi];
		sr = 0;
		sg = 0;
		sb = 0;
		for (int k = 0; k < bis_pkg::NBR; k++) begin
			sr += nb[k].red * wt[k];
			sg += nb[k].green * wt[k];
			sb += nb[k].blue * wt[k];
		end
		res.red   = bis_pkg::CHAN_W'(sr >> (2*FRAC));
		res.green = bis_pkg::CHAN_W'(sg >> (2*FRAC));
		res.blue  = bis_pkg::CHAN_W'(sb >> (2*FRAC));
		return res;
	endfunction

	function automatic rgb_t rand_rgb();
		return rgb_t'($urandom_range(0, 24'hffffff));
	endfunction

	// one past the largest destination index inside the image, at most 255
	function automatic int axis_limit(input int size,
			input logic [bis_pkg::STEP_W-1:0] step);
		int lim;
		if (step == 0)
			return 255;
		lim = ((size - 1) * (1 << FRAC)) / int'(step) + 1;
		return (lim > 255) ? 255 : lim;
	endfunction

	task automatic check_chan(input string name, input logic [bis_pkg::CHAN_W-1:0] want,
			input logic [bis_pkg::CHAN_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %02h actual %02h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// one input transaction, with burst/gap pacing
	task automatic send_item(input bis_pkg::kind_t kind,
			input logic [bis_pkg::COORD_W-1:0] col,
			input logic [bis_pkg::COORD_W-1:0] row, input rgb_t pix, input bit typed,
			input rgb_t want);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				@(negedge clk);
				pix_in_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(40, 200);
			else
				burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		pix_in_ch.valid    = 1'b1;
		pix_in_ch.kind     = kind;
		pix_in_ch.col      = col;
		pix_in_ch.row      = row;
		pix_in_ch.in_red   = pix.red;
		pix_in_ch.in_green = pix.green;
		pix_in_ch.in_blue  = pix.blue;
		do @(posedge clk); while (!pix_in_ch.ready);
		burst_left--;
		if (kind == bis_pkg::KIND_LOAD) begin
			src_image[row*IMG_W + col]  = pix;
			src_loaded[row*IMG_W + col] = 1'b1;
		end else begin
			pending_pixels.push_back(typed ? want : interp_pixel(col, row));
		end
	endtask

	// hold off input until all results are back and the pipeline has drained
	task automatic drain();
		@(negedge clk);
		pix_in_ch.valid = 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input bis_pkg::cfg_reg_t idx,
			input logic [bis_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			bis_pkg::REG_SOURCE_WIDTH:  cur_cfg.width  = val[bis_pkg::SIZE_W-1:0];
			bis_pkg::REG_SOURCE_HEIGHT: cur_cfg.height = val[bis_pkg::SIZE_W-1:0];
			bis_pkg::REG_STEP_X:        cur_cfg.sx     = val[bis_pkg::STEP_W-1:0];
			bis_pkg::REG_STEP_Y:        cur_cfg.sy     = val[bis_pkg::STEP_W-1:0];
		endcase
	endtask

	// reconfigure, fill the source region, then mixed loads and queries
	task automatic run_phase(input scale_cfg_t c);
		int w, h, lim_x, lim_y, pause_at, pick;
		logic [bis_pkg::COORD_W-1:0] qc, qr;
		drain();
		write_reg(bis_pkg::REG_SOURCE_WIDTH, bis_pkg::CFG_W'(c.width));
		write_reg(bis_pkg::REG_SOURCE_HEIGHT, bis_pkg::CFG_W'(c.height));
		write_reg(bis_pkg::REG_STEP_X, bis_pkg::CFG_W'(c.sx));
		write_reg(bis_pkg::REG_STEP_Y, bis_pkg::CFG_W'(c.sy));
		@(negedge clk);
		cfg_we = 1'b0;
		w = clamp_size(c.width, IMG_W);
		h = clamp_size(c.height, IMG_H);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				if (!src_loaded[y*IMG_W + x])
					send_item(bis_pkg::KIND_LOAD, bis_pkg::COORD_W'(x),
						bis_pkg::COORD_W'(y), rand_rgb(), 1'b0, '0);
		lim_x = axis_limit(w, c.sx);
		lim_y = axis_limit(h, c.sy);
		pause_at = $urandom_range(20, QUERIES_PHASE - 20);
		for (int i = 0; i < QUERIES_PHASE; i++) begin
			if (i == pause_at)
				drain();
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				// overwrite inside the active image
				send_item(bis_pkg::KIND_LOAD, bis_pkg::COORD_W'($urandom_range(0, w - 1)),
					bis_pkg::COORD_W'($urandom_range(0, h - 1)), rand_rgb(), 1'b0, '0);
			end else if (pick < 3) begin
				send_item(bis_pkg::KIND_LOAD, bis_pkg::COORD_W'($urandom_range(0, 255)),
					bis_pkg::COORD_W'($urandom_range(0, 255)), rand_rgb(), 1'b0, '0);
			end else begin
				qc = bis_pkg::COORD_W'($urandom_range(0, 1) ? $urandom_range(0, lim_x)
					: $urandom_range(0, 255));
				qr = bis_pkg::COORD_W'($urandom_range(0, 1) ? $urandom_range(0, lim_y)
					: $urandom_range(0, 255));
				send_item(bis_pkg::KIND_QUERY, qc, qr, rand_rgb(), 1'b0, '0);
			end
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern
	initial begin
		rx_mode_t mode;
		int left;
		pix_out_ch.ready = 1'b0;
		mode = RX_FLOW;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				left = $urandom_range(1, 60);
			end
			left--;
			case (mode)
				RX_FLOW:   pix_out_ch.ready = 1'b1;
				RX_RANDOM: pix_out_ch.ready = $urandom_range(0, 1);
				default:   pix_out_ch.ready = (left % 8) == 0;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result expected none actual %02h %02h %02h",
					$time, pix_out_ch.out_red, pix_out_ch.out_green, pix_out_ch.out_blue);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				check_chan("red", want.red, pix_out_ch.out_red);
				check_chan("green", want.green, pix_out_ch.out_green);
				check_chan("blue", want.blue, pix_out_ch.out_blue);
			end
		end
	end

	// stimulus
	initial begin
		scale_cfg_t c;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = bis_pkg::REG_SOURCE_WIDTH;
		cfg_data           = '0;
		pix_in_ch.valid    = 1'b0;
		pix_in_ch.kind     = bis_pkg::KIND_LOAD;
		pix_in_ch.col      = '0;
		pix_in_ch.row      = '0;
		pix_in_ch.in_red   = '0;
		pix_in_ch.in_green = '0;
		pix_in_ch.in_blue  = '0;
		cur_cfg            = '{bis_pkg::RST_SOURCE_WIDTH, bis_pkg::RST_SOURCE_HEIGHT,
			bis_pkg::RST_STEP_X, bis_pkg::RST_STEP_Y};
		mismatches         = 0;
		burst_left         = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_item(DIRECTED[i].kind, DIRECTED[i].col, DIRECTED[i].row,
				DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
			if (p < FIXED_PHASES) begin
				c = FIXED_CFGS[p];
			end else begin
				c.width  = bis_pkg::SIZE_W'(($urandom_range(0, 9) == 0) ? 0
					: $urandom_range(1, 16));
				c.height = bis_pkg::SIZE_W'(($urandom_range(0, 9) == 0) ? 0
					: $urandom_range(1, 16));
				c.sx = bis_pkg::STEP_W'(($urandom_range(0, 3) == 0)
					? $urandom_range(0, 21'h1fffff) : $urandom_range(256, 16384));
				c.sy = bis_pkg::STEP_W'(($urandom_range(0, 3) == 0)
					? $urandom_range(0, 21'h1fffff) : $urandom_range(256, 16384));
			end
			run_phase(c);
		end

		drain();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run time limit
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
